// File: hw/rtl/vtx_pkg.sv
// ----------------------------------------------------------------------------
// vtx_pkg
// Shared types and constants for the vertex transform block.
// ----------------------------------------------------------------------------
`default_nettype none
package vtx_pkg;
	localparam int NUM_REGS = 8;
	localparam int CFG_W = 64;
	localparam int IDX_W = 3;

	localparam int COORD_WIDTH = 32;
	localparam int COEF_WIDTH  = 16;

	localparam logic [IDX_W-1:0] REG_ROW0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW3 = 3'd3;
	localparam logic [IDX_W-1:0] REG_TXY  = 3'd4;
	localparam logic [IDX_W-1:0] REG_TZW  = 3'd5;
	localparam logic [IDX_W-1:0] REG_HALF = 3'd6;
	localparam logic [IDX_W-1:0] REG_PERS = 3'd7;

	localparam logic signed [31:0] RANGE_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] RANGE_MIN = -32'sh7fffffff;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               start_range;
		logic               last_in_batch;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic               w_zero;
		logic               batch_end;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAC, ST_ROWEND, ST_DIV, ST_SCALE, ST_TRACK, ST_OUT
	} vtx_state_t;

	typedef struct packed {
		logic load;      // capture input word
		logic mac;       // one multiply-accumulate step
		logic row_end;   // round, saturate, store row
		logic div_start;
		logic div_step;
		logic scale;     // ratio + 1, times half_width
		logic track;     // update range, build result
	} vtx_cmd_t;

	typedef struct packed {
		logic       last_col;
		logic       last_row;
		logic       div_done;
		logic       pers;
	} vtx_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/vertex_transform_xrange.sv
// ----------------------------------------------------------------------------
// vertex_transform_xrange
// 4x4 homogeneous point transform with screen-x range tracking.
// ----------------------------------------------------------------------------
// Takes no new point until the previous result has been handed off.
// Each point runs its MAC steps on one shared multiplier, plus, in perspective
// mode with nonzero w, 48 radix-2 divider steps and a scale step for x/w.
// Reset clears the config registers, controller and the tracked range.
`default_nettype none
module vertex_transform_xrange (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  vtx_pkg::in_word_t in_data,
	output logic              out_valid,
	input  wire               out_stall,
	output vtx_pkg::out_word_t out_data,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_index,
	input  wire [63:0]        cfg_data
);
	import vtx_pkg::*;

	logic [3*COEF_WIDTH-1:0] row_q [4];
	logic [63:0] txy_q, tzw_q;
	logic [31:0] half_q;
	logic        pers_q;
	vtx_cmd_t    cmd;
	vtx_sts_t    sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) row_q[i] <= '0;
			txy_q <= '0;
			tzw_q <= '0;
			half_q <= '0;
			pers_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0: row_q[0] <= cfg_data[3*COEF_WIDTH-1:0];
				REG_ROW1: row_q[1] <= cfg_data[3*COEF_WIDTH-1:0];
				REG_ROW2: row_q[2] <= cfg_data[3*COEF_WIDTH-1:0];
				REG_ROW3: row_q[3] <= cfg_data[3*COEF_WIDTH-1:0];
				REG_TXY:  txy_q <= cfg_data;
				REG_TZW:  tzw_q <= cfg_data;
				REG_HALF: half_q <= cfg_data[31:0];
				REG_PERS: pers_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	vtx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	vtx_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_word(in_data),
		.row_lin(row_q), .translate_xy(txy_q), .translate_zw(tzw_q),
		.half_width(half_q), .perspective_mode(pers_q), .result(out_data)
	);
endmodule
`default_nettype wire

// File: hw/rtl/vtx_datapath.sv
// ----------------------------------------------------------------------------
// vtx_datapath
// Sequenced multiply-accumulate, radix-2 divider and range tracking.
// ----------------------------------------------------------------------------
`default_nettype none
module vtx_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  vtx_pkg::vtx_cmd_t     cmd,
	output vtx_pkg::vtx_sts_t     sts,
	input  vtx_pkg::in_word_t     in_word,
	input  wire [3*vtx_pkg::COEF_WIDTH-1:0] row_lin [4],
	input  wire [63:0]            translate_xy,
	input  wire [63:0]            translate_zw,
	input  wire [31:0]            half_width,
	input  wire                   perspective_mode,
	output vtx_pkg::out_word_t    result
);
	import vtx_pkg::*;

	localparam int COEF_FRAC = COEF_WIDTH - 4;
	localparam int PROD_W = 32 + COEF_WIDTH;
	localparam int ACC_W = PROD_W + 4 + COEF_FRAC;
	localparam int DIV_W = 48;

	in_word_t              pt_q;
	logic [1:0]            col_q;
	logic [1:0]            row_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]    res_q [4];
	logic [5:0]            div_cnt_q;
	logic [DIV_W-1:0]      quo_q;
	logic [31:0]           rem_q;
	logic [31:0]           den_q;
	logic                  neg_q;
	logic signed [31:0]    sx_q;
	logic signed [31:0]    min_q;
	logic signed [31:0]    max_q;
	logic                  wz_q;

	logic signed [COEF_WIDTH-1:0] coef;
	logic signed [31:0]    pv;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] tr_ext;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] shr;
	logic signed [31:0]    row_sat;
	logic signed [31:0]    tr32;
	logic [32:0]           rem_sh;
	logic signed [33:0]    ratio;
	logic signed [33:0]    v;
	logic [33:0]           vmag;
	logic [65:0]           scl;
	logic [33:0]           q;
	logic signed [31:0]    sx_par;
	logic signed [31:0]    nx;
	logic signed [31:0]    nw;
	logic signed [31:0]    mn0;
	logic signed [31:0]    mx0;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	always_comb begin
		coef = row_lin[row_q][col_q*COEF_WIDTH +: COEF_WIDTH];
		case (col_q)
			2'd0: pv = pt_q.point_x;
			2'd1: pv = pt_q.point_y;
			default: pv = pt_q.point_z;
		endcase
		prod = ACC_W'(coef) * ACC_W'(pv);
		case (row_q)
			2'd0: tr32 = translate_xy[31:0];
			2'd1: tr32 = translate_xy[63:32];
			2'd2: tr32 = translate_zw[31:0];
			default: tr32 = translate_zw[63:32];
		endcase
		tr_ext = ACC_W'(tr32) <<< COEF_FRAC;
		rnd = acc_q + (ACC_W'(1) <<< (COEF_FRAC-1));
		shr = rnd >>> COEF_FRAC;
		if (shr > SAT_HI)      row_sat = 32'(SAT_HI);
		else if (shr < SAT_LO) row_sat = 32'(SAT_LO);
		else                   row_sat = 32'(shr);
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		nx = res_q[0];
		nw = res_q[3];
		if (neg_q) ratio = (quo_q > 48'h80000000) ? -34'sh80000000 : -$signed({2'b0, quo_q[31:0]});
		else       ratio = (quo_q > 48'h7fffffff) ? 34'sh7fffffff : $signed({2'b0, quo_q[31:0]});
		v = ratio + 34'sh10000;
		vmag = v[33] ? 34'(-v) : 34'(v);
		scl = 66'(vmag) * 66'(half_width);
		q = scl[65:32];
		sx_par = nx[31] ? -32'($signed({1'b0, 32'(-nx) >> 16}))
			: 32'($signed({1'b0, nx >> 16}));
		mn0 = pt_q.start_range ? RANGE_MAX : min_q;
		mx0 = pt_q.start_range ? RANGE_MIN : max_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_q <= in_word;
			col_q <= 2'd0;
			row_q <= 2'd0;
			acc_q <= '0;
		end
		if (cmd.mac) begin
			if (col_q == 2'd2) acc_q <= acc_q + prod + tr_ext;
			else acc_q <= acc_q + prod;
			col_q <= (col_q == 2'd2) ? 2'd0 : col_q + 2'd1;
		end
		if (cmd.row_end) begin
			res_q[row_q] <= row_sat;
			row_q <= row_q + 2'd1;
			acc_q <= '0;
		end
		if (cmd.div_start) begin
			quo_q <= DIV_W'(nx[31] ? 32'(-nx) : 32'(nx)) << 16;
			den_q <= nw[31] ? 32'(-nw) : 32'(nw);
			neg_q <= nx[31] ^ nw[31];
			rem_q <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= 32'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + 6'd1;
		end
		if (cmd.scale) begin
			if (v[33]) sx_q <= (q > 34'h80000000) ? -32'sh80000000 : -32'(q);
			else       sx_q <= (q > 34'h7fffffff) ? 32'sh7fffffff : 32'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= RANGE_MAX;
			max_q <= RANGE_MIN;
			wz_q <= 1'b0;
		end else if (cmd.track) begin
			if (perspective_mode && nw == 32'sd0) begin
				min_q <= mn0;
				max_q <= mx0;
				wz_q <= 1'b1;
			end else begin
				min_q <= ((perspective_mode ? sx_q : sx_par) < mn0)
					? (perspective_mode ? sx_q : sx_par) : mn0;
				max_q <= ((perspective_mode ? sx_q : sx_par) > mx0)
					? (perspective_mode ? sx_q : sx_par) : mx0;
				wz_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.last_col = (col_q == 2'd2);
		sts.last_row = perspective_mode ? (row_q == 2'd3) : (row_q == 2'd2);
		sts.div_done = (div_cnt_q == 6'(DIV_W));
		sts.pers = perspective_mode && (res_q[3] != 32'sd0);
		result.out_x = res_q[0];
		result.out_y = res_q[1];
		result.out_z = res_q[2];
		result.out_w = perspective_mode ? res_q[3] : 32'sd0;
		result.range_low = min_q;
		result.range_high = max_q;
		result.w_zero = wz_q;
		result.batch_end = pt_q.last_in_batch;
	end
endmodule
`default_nettype wire

// File: hw/rtl/vtx_ctrl.sv
// ----------------------------------------------------------------------------
// vtx_ctrl
// Sequencer for row accumulation, division, scaling and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module vtx_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire                out_stall,
	input  vtx_pkg::vtx_sts_t  sts,
	output vtx_pkg::vtx_cmd_t  cmd
);
	import vtx_pkg::*;

	vtx_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MAC;
			ST_MAC:    if (sts.last_col) state_d = ST_ROWEND;
			ST_ROWEND: if (sts.last_row) state_d = ST_DIV;
				else state_d = ST_MAC;
			ST_DIV:    state_d = sts.pers ? ST_SCALE : ST_TRACK;
			ST_SCALE:  if (sts.div_done) state_d = ST_TRACK;
			ST_TRACK:  state_d = ST_OUT;
			ST_OUT:    if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_MAC:    cmd.mac = 1'b1;
			ST_ROWEND: cmd.row_end = 1'b1;
			ST_DIV:    cmd.div_start = 1'b1;
			ST_SCALE: begin
				cmd.div_step = !sts.div_done;
				cmd.scale = sts.div_done;
			end
			ST_TRACK:  cmd.track = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// File: hw/rtl/vtx_checker.sv
// ----------------------------------------------------------------------------
// vtx_checker
// Port-level checks for the vertex transform block.
// ----------------------------------------------------------------------------
`default_nettype none
module vtx_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input vtx_pkg::out_word_t out_data
);
	import vtx_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.range_low != RANGE_MAX |->
		out_data.range_low <= out_data.range_high)
		else $error("range inverted");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted too early");
endmodule

bind vertex_transform_xrange vtx_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// File: tb/tb_vertex_transform_xrange.sv
// ----------------------------------------------------------------------------
// tb_vertex_transform_xrange
// Drives points through the vertex transform with random and directed matrices, both
// projection modes and random idling on both sides, and compares every
// result word against a fixed-point transform and range tracker kept here.
// ----------------------------------------------------------------------------
`default_nettype none

class xform_scoreboard;
	logic [47:0]  lin [4];
	logic [63:0]  txy, tzw;
	logic [31:0]  hw;
	logic         pers;
	longint       lo_x, hi_x;
	vtx_pkg::out_word_t pending [$];
	int           errors;

	function new();
		for (int i = 0; i < 4; i++) lin[i] = '0;
		txy = '0; tzw = '0; hw = '0; pers = 1'b0;
		lo_x = 64'sh7fffffff; hi_x = -64'sh7fffffff;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			vtx_pkg::REG_ROW0, vtx_pkg::REG_ROW1, vtx_pkg::REG_ROW2,
			vtx_pkg::REG_ROW3: lin[idx[1:0]] = val[47:0];
			vtx_pkg::REG_TXY:  txy = val;
			vtx_pkg::REG_TZW:  tzw = val;
			vtx_pkg::REG_HALF: hw = val[31:0];
			default:           pers = val[0];
		endcase
	endfunction

	function longint row_dot(int r, longint px, longint py, longint pz);
		longint t, acc;
		logic [63:0] tr;
		tr = (r < 2) ? txy : tzw;
		t = (r & 1) ? longint'($signed(tr[63:32])) : longint'($signed(tr[31:0]));
		acc = longint'($signed(lin[r][15:0])) * px
			+ longint'($signed(lin[r][31:16])) * py
			+ longint'($signed(lin[r][47:32])) * pz + t * 4096 + 2048;
		acc = acc >>> 12;
		if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
		if (acc < -64'sh80000000) acc = -64'sh80000000;
		return acc;
	endfunction

	function longint screen_col(longint x, longint w);
		logic [63:0] nm, dm, qm, m, q;
		longint ratio, v;
		bit neg;
		neg = (x < 0) != (w < 0);
		nm = (x < 0 ? -x : x) << 16;
		dm = w < 0 ? -w : w;
		qm = nm / dm;
		if (neg) ratio = qm > 64'h80000000 ? -64'sh80000000 : -longint'(qm);
		else ratio = qm > 64'h7fffffff ? 64'sh7fffffff : longint'(qm);
		v = ratio + 65536;
		m = v < 0 ? -v : v;
		q = (m * {32'd0, hw}) >> 32;
		if (v < 0) return q > 64'h80000000 ? -64'sh80000000 : -longint'(q);
		return q > 64'h7fffffff ? 64'sh7fffffff : longint'(q);
	endfunction

	function void note_point(vtx_pkg::in_word_t p);
		vtx_pkg::out_word_t r;
		longint px, py, pz, nx, nw, sx;
		bit track;
		px = p.point_x; py = p.point_y; pz = p.point_z;
		if (p.start_range) begin
			lo_x = 64'sh7fffffff; hi_x = -64'sh7fffffff;
		end
		nx = row_dot(0, px, py, pz);
		nw = 0; sx = 0; track = 1; r = '0;
		if (pers) begin
			nw = row_dot(3, px, py, pz);
			if (nw == 0) track = 0;
			else sx = screen_col(nx, nw);
		end else begin
			sx = nx >= 0 ? (nx >>> 16) : -((-nx) >>> 16);
		end
		if (track) begin
			if (sx > hi_x) hi_x = sx;
			if (sx < lo_x) lo_x = sx;
		end
		r.out_x = nx[31:0];
		r.out_y = 32'(row_dot(1, px, py, pz));
		r.out_z = 32'(row_dot(2, px, py, pz));
		r.out_w = nw[31:0];
		r.range_low = lo_x[31:0];
		r.range_high = hi_x[31:0];
		r.w_zero = !track;
		r.batch_end = p.last_in_batch;
		pending.push_back(r);
	endfunction

	function void check_result(vtx_pkg::out_word_t a);
		vtx_pkg::out_word_t e;
		if (pending.size() == 0) begin
			$error("unexpected result word %h", a);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.out_x !== e.out_x) begin $error("out_x exp %h got %h", e.out_x, a.out_x); errors++; end
		if (a.out_y !== e.out_y) begin $error("out_y exp %h got %h", e.out_y, a.out_y); errors++; end
		if (a.out_z !== e.out_z) begin $error("out_z exp %h got %h", e.out_z, a.out_z); errors++; end
		if (a.out_w !== e.out_w) begin $error("out_w exp %h got %h", e.out_w, a.out_w); errors++; end
		if (a.range_low !== e.range_low) begin
			$error("range_low exp %h got %h", e.range_low, a.range_low); errors++;
		end
		if (a.range_high !== e.range_high) begin
			$error("range_high exp %h got %h", e.range_high, a.range_high); errors++;
		end
		if (a.w_zero !== e.w_zero) begin $error("w_zero exp %b got %b", e.w_zero, a.w_zero); errors++; end
		if (a.batch_end !== e.batch_end) begin
			$error("batch_end exp %b got %b", e.batch_end, a.batch_end); errors++;
		end
	endfunction
endclass

module tb_vertex_transform_xrange;
	timeunit 1ns;
	timeprecision 1ps;
	import vtx_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic       clk, arst_n;
	logic       in_valid, in_stall, out_valid, out_stall;
	in_word_t   in_data;
	out_word_t  out_data;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	xform_scoreboard sb;
	bit   calm;
	bit   hold_off;
	int   idle_cycles;

	vertex_transform_xrange uut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'hffffffff : 32'h00010000;
			4: return {{16{1'b0}}, 16'($urandom)} - 32'h8000 + ($urandom_range(0, 1) << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic load_matrix(int style, bit persp);
		for (int r = 0; r < 4; r++) begin
			case (style)
				0: write_reg(r[2:0], 64'({rand_coef(), rand_coef(), rand_coef()}));
				1: write_reg(r[2:0], 64'(r == 3 ? 48'h0 : {16'h7fff, 16'h7fff, 16'h7fff}));
				2: write_reg(r[2:0], 64'({16'h8000, 16'h8000, 16'h8000}));
				default: write_reg(r[2:0], 64'(48'h1000 << (16 * (r % 3))));
			endcase
		end
		write_reg(REG_TXY, {rand_word(), rand_word()});
		write_reg(REG_TZW, style == 3 ? {32'h00010000, rand_word()} : {rand_word(), rand_word()});
		write_reg(REG_HALF, 64'(style == 1 ? 32'hffffffff : style == 2 ? 32'h0 : $urandom));
		write_reg(REG_PERS, {63'd0, persp});
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(in_word_t p);
		if (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while (!calm && $urandom_range(0, 99) < 14) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_point(p);
		@(negedge clk);
	endtask

	task automatic send_random(int n, bit well_formed);
		in_word_t p;
		for (int i = 0; i < n; i++) begin
			p.point_x = rand_word();
			p.point_y = rand_word();
			p.point_z = rand_word();
			if (well_formed) begin
				p.point_x = $signed(p.point_x) >>> $urandom_range(0, 12);
				p.point_y = $signed(p.point_y) >>> $urandom_range(0, 12);
				p.point_z = $signed(p.point_z) >>> $urandom_range(0, 12);
			end
			p.start_range = $urandom_range(0, 9) == 0;
			p.last_in_batch = $urandom_range(0, 7) == 0;
			send_point(p);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("vertex_transform_xrange verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= !calm && $urandom_range(0, 99) < 14;
	end

	initial begin
		in_word_t p;
		sb = new();
		arst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		cfg_we = 1'b0; cfg_index = REG_ROW0; cfg_data = '0;
		calm = 1'b0; hold_off = 1'b0; idle_cycles = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset registers, then identity-ish matrices and extremes
		p = '{32'h7fffffff, 32'h80000000, 32'h0, 1'b0, 1'b1};
		send_point(p);
		settle();
		load_matrix(3, 1'b0);
		p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0}; send_point(p);
		p = '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0}; send_point(p);
		p = '{32'hffff8000, 32'h00018000, 32'h0, 1'b0, 1'b1}; send_point(p);
		p = '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}; send_point(p);
		settle();
		load_matrix(1, 1'b1);
		p = '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}; send_point(p);
		p = '{32'h7fffffff, 32'hffffffff, 32'h80000000, 1'b0, 1'b1}; send_point(p);
		settle();
		load_matrix(2, 1'b1);
		p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1}; send_point(p);
		p = '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0}; send_point(p);
		settle();
		load_matrix(3, 1'b1);
		p = '{32'h00020000, 32'h0, 32'h0, 1'b1, 1'b0}; send_point(p);
		p = '{32'hfffe0000, 32'h0, 32'h0, 1'b0, 1'b0}; send_point(p);
		p = '{32'h7fffffff, 32'h0, 32'h0, 1'b0, 1'b1}; send_point(p);

		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(negedge clk);
				hold_off = 1'b0;
			end
			send_random(20, 1'b1);
		join
		calm = 1'b1;
		send_random(40, 1'b1);
		calm = 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			load_matrix(ph % 4 == 3 ? 0 : ph % 4, ph[0]);
			send_random(80, ph != 5);
		end

		settle();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("vertex_transform_xrange verification clean");
		else
			$display("vertex_transform_xrange verification failed");
		$finish;
	end
endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/vtx_pkg.sv
hw/rtl/vtx_datapath.sv
hw/rtl/vtx_ctrl.sv
hw/rtl/vertex_transform_xrange.sv
hw/rtl/vtx_checker.sv
tb/tb_vertex_transform_xrange.sv
